/* design/tfdf_pkg.sv */
// Shared constants, widths and types for the TPFA face Darcy flux pipeline.
// No dependencies; every design file refers to this package by scoped names.
`default_nettype none

package tfdf_pkg;

    // Phases used; mobility and gravity fields of higher phases are ignored.
    localparam int PHASE_COUNT = 3;
    localparam int MAX_PHASES = 3;

    localparam int NUM_STAGES = 6;

    localparam int W_VAL  = 32;                 // signed Q16.16 fields
    localparam int W_UNS  = 31;                 // non-negative Q15.16 fields
    localparam int FRAC   = 16;
    localparam int W_DP   = W_VAL + 1;          // exact pressure drop
    localparam int W_X    = W_VAL + 2;          // drop plus gravity-capillary term
    localparam int W_XMAG = W_X - 1;            // magnitude of that sum
    localparam int W_PROD = W_UNS + W_XMAG;     // mobility times magnitude
    localparam int W_TMAG = W_PROD + 1 - FRAC;  // rounded phase term magnitude
    localparam int W_TERM = W_TMAG + 1;         // signed phase term
    localparam int W_SUM  = W_TERM + $clog2(PHASE_COUNT);
    localparam int W_MAG  = W_SUM;              // magnitude of the phase sum
    localparam int W_LO   = 32;                 // low slice of the magnitude
    localparam int W_HI   = W_MAG - W_LO;       // high slice of the magnitude
    localparam int W_PPLO = W_UNS + W_LO;
    localparam int W_PPHI = W_UNS + W_HI;
    localparam int W_FULL = W_UNS + W_MAG;      // transmissibility times magnitude
    localparam int W_R    = W_FULL + 1 - FRAC;  // rounded flux magnitude

    localparam logic [W_PROD:0] ROUND_PROD = (W_PROD + 1)'(1) << (FRAC - 1);
    localparam logic [W_FULL:0] ROUND_FULL = (W_FULL + 1)'(1) << (FRAC - 1);

    localparam logic [W_VAL-1:0] FLUX_MAX = {1'b0, {(W_VAL - 1){1'b1}}};
    localparam logic [W_VAL-1:0] FLUX_MIN = {1'b1, {(W_VAL - 1){1'b0}}};
    localparam logic [W_R-1:0]   R_POS_LIMIT = W_R'(FLUX_MAX);
    localparam logic [W_R-1:0]   R_NEG_LIMIT = W_R'(FLUX_MIN);

    // Face kinds
    localparam logic [1:0] MODE_INTERIOR    = 2'd0;
    localparam logic [1:0] MODE_BC_PRESSURE = 2'd1;
    localparam logic [1:0] MODE_BC_FLUX     = 2'd2;
    localparam logic [1:0] MODE_BC_NONE     = 2'd3;

    typedef logic [PHASE_COUNT-1:0][W_UNS-1:0]  mob_vec_t;
    typedef logic [PHASE_COUNT-1:0][W_VAL-1:0]  gcap_vec_t;
    typedef logic [PHASE_COUNT-1:0][W_XMAG-1:0] xmag_vec_t;
    typedef logic [PHASE_COUNT-1:0][W_PROD-1:0] prod_vec_t;
    typedef logic [PHASE_COUNT-1:0][W_TERM-1:0] term_vec_t;

    // Per-stage load enables, first stage to output stage
    typedef struct packed {
        logic drop;
        logic mult;
        logic round;
        logic sum;
        logic part;
        logic out;
    } stage_en_t;

endpackage

`default_nettype wire

/* design/tfdf_drop.sv */
// Stage 1: pressure drop by face kind, per-phase drop plus gravity term.
// Depends on tfdf_pkg.
`default_nettype none

module tfdf_drop (
    input  wire logic                               clk,
    input  wire tfdf_pkg::stage_en_t                en,
    input  wire logic [1:0]                         mode,
    input  wire logic                               outside_first,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  pressure_first,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  pressure_second,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  bc_value,
    input  wire logic [tfdf_pkg::W_UNS-1:0]         transmissibility,
    input  wire tfdf_pkg::mob_vec_t                 mob,
    input  wire tfdf_pkg::gcap_vec_t                gcap,
    output logic [tfdf_pkg::PHASE_COUNT-1:0]        xneg,
    output tfdf_pkg::xmag_vec_t                     xmag,
    output tfdf_pkg::mob_vec_t                      mob_out,
    output logic [tfdf_pkg::W_UNS-1:0]              trans,
    output logic                                    bypass,
    output logic [tfdf_pkg::W_VAL-1:0]              bypass_value
);

    logic signed [tfdf_pkg::W_VAL-1:0] op_a;
    logic signed [tfdf_pkg::W_VAL-1:0] op_b;
    logic signed [tfdf_pkg::W_DP-1:0]  dp;
    logic signed [tfdf_pkg::W_X-1:0]   x [tfdf_pkg::PHASE_COUNT];

    logic [tfdf_pkg::PHASE_COUNT-1:0] xneg_reg, xneg_next;
    tfdf_pkg::xmag_vec_t             xmag_reg, xmag_next;
    tfdf_pkg::mob_vec_t              mob_reg;
    logic [tfdf_pkg::W_UNS-1:0]      trans_reg;
    logic                            bypass_reg, bypass_next;
    logic [tfdf_pkg::W_VAL-1:0]      bval_reg, bval_next;

    always_comb
    begin
        op_a = pressure_first;
        op_b = pressure_second;
        case (mode)
            tfdf_pkg::MODE_BC_PRESSURE:
            begin
                if (outside_first)
                begin
                    op_a = bc_value;
                end
                else
                begin
                    op_b = bc_value;
                end
            end
            default:
            begin
                op_a = pressure_first;
                op_b = pressure_second;
            end
        endcase
        dp = tfdf_pkg::W_DP'(op_a) - tfdf_pkg::W_DP'(op_b);

        for (int p = 0; p < tfdf_pkg::PHASE_COUNT; p++)
        begin
            x[p] = tfdf_pkg::W_X'(dp) + tfdf_pkg::W_X'($signed(gcap[p]));
            xneg_next[p] = x[p][tfdf_pkg::W_X-1];
            xmag_next[p] = xneg_next[p] ? tfdf_pkg::W_XMAG'(-x[p])
                                        : tfdf_pkg::W_XMAG'(x[p]);
        end

        // Flux and no-condition faces skip the arithmetic
        bypass_next = (mode == tfdf_pkg::MODE_BC_FLUX) || (mode == tfdf_pkg::MODE_BC_NONE);
        bval_next   = (mode == tfdf_pkg::MODE_BC_FLUX) ? bc_value : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en.drop)
        begin
            xneg_reg   <= xneg_next;
            xmag_reg   <= xmag_next;
            mob_reg    <= mob;
            trans_reg  <= transmissibility;
            bypass_reg <= bypass_next;
            bval_reg   <= bval_next;
        end
    end

    assign xneg         = xneg_reg;
    assign xmag         = xmag_reg;
    assign mob_out      = mob_reg;
    assign trans        = trans_reg;
    assign bypass       = bypass_reg;
    assign bypass_value = bval_reg;

endmodule

`default_nettype wire

/* design/tfdf_phase.sv */
// Stages 2 to 4: per-phase mobility products, rounding, signed sum and magnitude.
// Depends on tfdf_pkg.
`default_nettype none

module tfdf_phase (
    input  wire logic                               clk,
    input  wire tfdf_pkg::stage_en_t                en,
    input  wire logic [tfdf_pkg::PHASE_COUNT-1:0]   xneg,
    input  wire tfdf_pkg::xmag_vec_t                xmag,
    input  wire tfdf_pkg::mob_vec_t                 mob,
    input  wire logic [tfdf_pkg::W_UNS-1:0]         trans_in,
    input  wire logic                               bypass_in,
    input  wire logic [tfdf_pkg::W_VAL-1:0]         bval_in,
    output logic                                    neg,
    output logic [tfdf_pkg::W_MAG-1:0]              mag,
    output logic [tfdf_pkg::W_UNS-1:0]              trans,
    output logic                                    bypass,
    output logic [tfdf_pkg::W_VAL-1:0]              bypass_value
);

    // Stage 2: multiply
    tfdf_pkg::prod_vec_t             prod_reg, prod_next;
    logic [tfdf_pkg::PHASE_COUNT-1:0] xneg2_reg;
    logic [tfdf_pkg::W_UNS-1:0]      trans2_reg;
    logic                            bypass2_reg;
    logic [tfdf_pkg::W_VAL-1:0]      bval2_reg;

    // Stage 3: round and apply sign
    tfdf_pkg::term_vec_t             term_reg, term_next;
    logic [tfdf_pkg::W_UNS-1:0]      trans3_reg;
    logic                            bypass3_reg;
    logic [tfdf_pkg::W_VAL-1:0]      bval3_reg;

    // Stage 4: sum and magnitude
    logic                            neg_reg, neg_next;
    logic [tfdf_pkg::W_MAG-1:0]      mag_reg, mag_next;
    logic [tfdf_pkg::W_UNS-1:0]      trans4_reg;
    logic                            bypass4_reg;
    logic [tfdf_pkg::W_VAL-1:0]      bval4_reg;

    logic [tfdf_pkg::W_PROD:0]         rounded [tfdf_pkg::PHASE_COUNT];
    logic [tfdf_pkg::W_TMAG-1:0]       tmag [tfdf_pkg::PHASE_COUNT];
    logic signed [tfdf_pkg::W_SUM-1:0] sum;

    always_comb
    begin
        for (int p = 0; p < tfdf_pkg::PHASE_COUNT; p++)
        begin
            prod_next[p] = tfdf_pkg::W_PROD'(mob[p]) * tfdf_pkg::W_PROD'(xmag[p]);
        end

        for (int p = 0; p < tfdf_pkg::PHASE_COUNT; p++)
        begin
            rounded[p] = (tfdf_pkg::W_PROD + 1)'(prod_reg[p]) + tfdf_pkg::ROUND_PROD;
            tmag[p]    = rounded[p][tfdf_pkg::W_PROD:tfdf_pkg::FRAC];
            term_next[p] = xneg2_reg[p] ? -tfdf_pkg::W_TERM'(tmag[p])
                                        : tfdf_pkg::W_TERM'(tmag[p]);
        end

        sum = '0;
        for (int p = 0; p < tfdf_pkg::PHASE_COUNT; p++)
        begin
            sum = sum + tfdf_pkg::W_SUM'($signed(term_reg[p]));
        end
        neg_next = sum[tfdf_pkg::W_SUM-1];
        mag_next = neg_next ? tfdf_pkg::W_MAG'(-sum) : tfdf_pkg::W_MAG'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (en.mult)
        begin
            prod_reg    <= prod_next;
            xneg2_reg   <= xneg;
            trans2_reg  <= trans_in;
            bypass2_reg <= bypass_in;
            bval2_reg   <= bval_in;
        end
        if (en.round)
        begin
            term_reg    <= term_next;
            trans3_reg  <= trans2_reg;
            bypass3_reg <= bypass2_reg;
            bval3_reg   <= bval2_reg;
        end
        if (en.sum)
        begin
            neg_reg     <= neg_next;
            mag_reg     <= mag_next;
            trans4_reg  <= trans3_reg;
            bypass4_reg <= bypass3_reg;
            bval4_reg   <= bval3_reg;
        end
    end

    assign neg          = neg_reg;
    assign mag          = mag_reg;
    assign trans        = trans4_reg;
    assign bypass       = bypass4_reg;
    assign bypass_value = bval4_reg;

endmodule

`default_nettype wire

/* design/tfdf_scale.sv */
// Stages 5 and 6: transmissibility product in two slices, rounding, saturation
// and the output register. Depends on tfdf_pkg.
`default_nettype none

module tfdf_scale (
    input  wire logic                          clk,
    input  wire tfdf_pkg::stage_en_t           en,
    input  wire logic                          neg_in,
    input  wire logic [tfdf_pkg::W_MAG-1:0]    mag,
    input  wire logic [tfdf_pkg::W_UNS-1:0]    trans,
    input  wire logic                          bypass_in,
    input  wire logic [tfdf_pkg::W_VAL-1:0]    bval_in,
    output logic [tfdf_pkg::W_VAL-1:0]         face_flux,
    output logic                               saturated
);

    logic [tfdf_pkg::W_PPLO-1:0] pp_lo_reg, pp_lo_next;
    logic [tfdf_pkg::W_PPHI-1:0] pp_hi_reg, pp_hi_next;
    logic                        neg5_reg;
    logic                        bypass5_reg;
    logic [tfdf_pkg::W_VAL-1:0]  bval5_reg;

    logic [tfdf_pkg::W_VAL-1:0]  flux_reg, flux_next;
    logic                        sat_reg, sat_next;

    logic [tfdf_pkg::W_FULL:0]   full;
    logic [tfdf_pkg::W_R-1:0]    r;

    always_comb
    begin
        pp_lo_next = tfdf_pkg::W_PPLO'(trans) *
                     tfdf_pkg::W_PPLO'(mag[tfdf_pkg::W_LO-1:0]);
        pp_hi_next = tfdf_pkg::W_PPHI'(trans) *
                     tfdf_pkg::W_PPHI'(mag[tfdf_pkg::W_MAG-1:tfdf_pkg::W_LO]);

        full = (tfdf_pkg::W_FULL + 1)'(pp_lo_reg)
             + ((tfdf_pkg::W_FULL + 1)'(pp_hi_reg) << tfdf_pkg::W_LO)
             + tfdf_pkg::ROUND_FULL;
        r = full[tfdf_pkg::W_FULL:tfdf_pkg::FRAC];

        if (bypass5_reg)
        begin
            flux_next = bval5_reg;
            sat_next  = 1'b0;
        end
        else if (neg5_reg)
        begin
            if (r > tfdf_pkg::R_NEG_LIMIT)
            begin
                flux_next = tfdf_pkg::FLUX_MIN;
                sat_next  = 1'b1;
            end
            else
            begin
                flux_next = tfdf_pkg::W_VAL'(-r);
                sat_next  = 1'b0;
            end
        end
        else
        begin
            if (r > tfdf_pkg::R_POS_LIMIT)
            begin
                flux_next = tfdf_pkg::FLUX_MAX;
                sat_next  = 1'b1;
            end
            else
            begin
                flux_next = tfdf_pkg::W_VAL'(r);
                sat_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.part)
        begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            neg5_reg    <= neg_in;
            bypass5_reg <= bypass_in;
            bval5_reg   <= bval_in;
        end
        if (en.out)
        begin
            flux_reg <= flux_next;
            sat_reg  <= sat_next;
        end
    end

    assign face_flux = flux_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

/* design/tpfa_face_darcy_flux_top.sv */
// Top level of the TPFA face Darcy flux pipeline: valid tracking and stalls.
// Depends on tfdf_pkg, tfdf_drop, tfdf_phase and tfdf_scale.
//
//   channel   direction   handshake                 payload
//   face      in          face_valid / face_ready   mode .. gravity_cap_phase2
//   flux      out         flux_valid / flux_ready   face_flux, saturated
//
// Six register stages; the first loads at the face transaction, and its flux is valid
// once it reaches the output stage; one face is taken every cycle when the output drains.
// Stage depth is set by the 31x33 mobility multipliers and the split
// transmissibility product. Reset clears only the stage valid bits.
// A stalled output holds; empty stages upstream keep filling until full.
`default_nettype none

module tpfa_face_darcy_flux_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               face_valid,
    output logic                                    face_ready,
    input  wire logic [1:0]                         mode,
    input  wire logic                               outside_first,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  pressure_first,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  pressure_second,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  bc_value,
    input  wire logic [tfdf_pkg::W_UNS-1:0]         transmissibility,
    input  wire logic [tfdf_pkg::W_UNS-1:0]         mobility_phase0,
    input  wire logic [tfdf_pkg::W_UNS-1:0]         mobility_phase1,
    input  wire logic [tfdf_pkg::W_UNS-1:0]         mobility_phase2,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  gravity_cap_phase0,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  gravity_cap_phase1,
    input  wire logic signed [tfdf_pkg::W_VAL-1:0]  gravity_cap_phase2,
    output logic                                    flux_valid,
    input  wire logic                               flux_ready,
    output logic signed [tfdf_pkg::W_VAL-1:0]       face_flux,
    output logic                                    saturated
);

    localparam int LAST = tfdf_pkg::NUM_STAGES - 1;

    logic [tfdf_pkg::NUM_STAGES-1:0] valid_reg, valid_next;
    logic [tfdf_pkg::NUM_STAGES-1:0] load;
    tfdf_pkg::stage_en_t             en;

    logic [tfdf_pkg::MAX_PHASES-1:0][tfdf_pkg::W_UNS-1:0] mob_all;
    logic [tfdf_pkg::MAX_PHASES-1:0][tfdf_pkg::W_VAL-1:0] gcap_all;
    tfdf_pkg::mob_vec_t  mob_in;
    tfdf_pkg::gcap_vec_t gcap_in;

    logic [tfdf_pkg::PHASE_COUNT-1:0] d_xneg;
    tfdf_pkg::xmag_vec_t             d_xmag;
    tfdf_pkg::mob_vec_t              d_mob;
    logic [tfdf_pkg::W_UNS-1:0]      d_trans;
    logic                            d_bypass;
    logic [tfdf_pkg::W_VAL-1:0]      d_bval;

    logic                            p_neg;
    logic [tfdf_pkg::W_MAG-1:0]      p_mag;
    logic [tfdf_pkg::W_UNS-1:0]      p_trans;
    logic                            p_bypass;
    logic [tfdf_pkg::W_VAL-1:0]      p_bval;

    logic [tfdf_pkg::W_VAL-1:0]      flux_word;

    assign mob_all  = {mobility_phase2, mobility_phase1, mobility_phase0};
    assign gcap_all = {gravity_cap_phase2, gravity_cap_phase1, gravity_cap_phase0};

    always_comb
    begin
        for (int p = 0; p < tfdf_pkg::PHASE_COUNT; p++)
        begin
            mob_in[p]  = mob_all[p];
            gcap_in[p] = gcap_all[p];
        end
    end

    // A stage loads when it is empty or its content moves on
    always_comb
    begin
        load[LAST] = !valid_reg[LAST] || flux_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = load[0] ? face_valid : valid_reg[0];
        for (int k = 1; k < tfdf_pkg::NUM_STAGES; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en.drop  = load[0];
    assign en.mult  = load[1];
    assign en.round = load[2];
    assign en.sum   = load[3];
    assign en.part  = load[4];
    assign en.out   = load[5];

    assign face_ready = load[0];
    assign flux_valid = valid_reg[LAST];

    tfdf_drop u_drop (
        .clk              (clk),
        .en               (en),
        .mode             (mode),
        .outside_first    (outside_first),
        .pressure_first   (pressure_first),
        .pressure_second  (pressure_second),
        .bc_value         (bc_value),
        .transmissibility (transmissibility),
        .mob              (mob_in),
        .gcap             (gcap_in),
        .xneg             (d_xneg),
        .xmag             (d_xmag),
        .mob_out          (d_mob),
        .trans            (d_trans),
        .bypass           (d_bypass),
        .bypass_value     (d_bval)
    );

    tfdf_phase u_phase (
        .clk          (clk),
        .en           (en),
        .xneg         (d_xneg),
        .xmag         (d_xmag),
        .mob          (d_mob),
        .trans_in     (d_trans),
        .bypass_in    (d_bypass),
        .bval_in      (d_bval),
        .neg          (p_neg),
        .mag          (p_mag),
        .trans        (p_trans),
        .bypass       (p_bypass),
        .bypass_value (p_bval)
    );

    tfdf_scale u_scale (
        .clk       (clk),
        .en        (en),
        .neg_in    (p_neg),
        .mag       (p_mag),
        .trans     (p_trans),
        .bypass_in (p_bypass),
        .bval_in   (p_bval),
        .face_flux (flux_word),
        .saturated (saturated)
    );

    assign face_flux = $signed(flux_word);

endmodule

`default_nettype wire

/* design/tfdf_checker.sv */
// Port-level checks for the TPFA face Darcy flux pipeline, bound to the top.
// Depends on tfdf_pkg and tpfa_face_darcy_flux_top.
`default_nettype none

module tfdf_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        face_valid,
    input wire logic                        face_ready,
    input wire logic                        flux_valid,
    input wire logic                        flux_ready,
    input wire logic [tfdf_pkg::W_VAL-1:0]  face_flux,
    input wire logic                        saturated
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        flux_valid && !flux_ready |=> flux_valid && $stable(face_flux) && $stable(saturated))
        else $error("stalled flux transaction changed");

    // Input back-pressure only when the output itself is stalled
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !face_ready |-> flux_valid && !flux_ready)
        else $error("face_ready low without output stall");

    // A clipped flux sits at one of the two limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        flux_valid && saturated |->
            (face_flux == tfdf_pkg::FLUX_MAX) || (face_flux == tfdf_pkg::FLUX_MIN))
        else $error("saturated flag with unclipped flux");

    // With the output draining, a face comes out after the pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && face_ready ##1 flux_ready ##1 flux_ready ##1 flux_ready
            ##1 flux_ready ##1 flux_ready |=> flux_valid)
        else $error("flux transaction missing after pipeline depth");

    // Nothing comes out of an empty pipeline right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !flux_valid)
        else $error("flux_valid high after reset");

endmodule

bind tpfa_face_darcy_flux_top tfdf_checker u_tfdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .face_valid (face_valid),
    .face_ready (face_ready),
    .flux_valid (flux_valid),
    .flux_ready (flux_ready),
    .face_flux  (face_flux),
    .saturated  (saturated)
);

`default_nettype wire
